[src/cthit_pkg.sv]
// Package for the circle table hit test: result widths, request codes and state type.
`default_nettype none

package cthit_pkg;

    // Fixed widths of the result fields.
    localparam int unsigned HIT_INDEX_W    = 6;
    localparam int unsigned STORED_COUNT_W = 7;

    typedef logic [HIT_INDEX_W-1:0]    hit_index_t;
    typedef logic [STORED_COUNT_W-1:0] stored_count_t;

    // Request codes carried by req_type.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

endpackage

`default_nettype wire

[src/circle_table_hit_test.sv]
// Circle table with a newest-first point hit test over a pipelined compare unit.
//
//   channel   handshake          fields
//   -------   ----------------   -----------------------------------------------
//   request   start, busy        req_type, circ_x, circ_y, circ_w, circ_h, pt_x, pt_y
//   result    done (one cycle)   hit_found, hit_index, stored_count, insert_refused
//
// An item is taken when start is high and busy is low. An insert gives its result
// in the next cycle and never raises busy. A query holds busy while its scan runs:
// the scan reads one table entry per cycle from the memory port and feeds a
// three-stage distance compare unit, stopping at the first hit.
// Reset clears the circle count and the control state; the table itself is not cleared.
// The result strobe lasts one cycle; the receiver cannot stall it.
`default_nettype none

module circle_table_hit_test #(
    parameter int unsigned MAX_CIRCLES = 64,
    parameter int unsigned COORD_BITS  = 10
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire                                 req_type,
    input  wire  [COORD_BITS-1:0]               circ_x,
    input  wire  [COORD_BITS-1:0]               circ_y,
    input  wire  [COORD_BITS-1:0]               circ_w,
    input  wire  [COORD_BITS-1:0]               circ_h,
    input  wire  [COORD_BITS-1:0]               pt_x,
    input  wire  [COORD_BITS-1:0]               pt_y,
    output logic                                done,
    output logic                                hit_found,
    output cthit_pkg::hit_index_t               hit_index,
    output cthit_pkg::stored_count_t            stored_count,
    output logic                                insert_refused
);

    localparam int unsigned C      = COORD_BITS;
    localparam int unsigned IDX_W  = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_CIRCLES + 1);
    localparam int unsigned ENT_W  = 4 * C;
    localparam int unsigned ABS_W  = C + 1;
    localparam int unsigned SQ_W   = 2 * C + 2;
    localparam int unsigned SUM_W  = 2 * C + 3;

    // Sequencer and table control.
    cthit_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [C-1:0]       px_reg, py_reg;
    logic               accept;
    logic               mem_we;
    logic               table_full;

    // Scan address issue.
    logic               iss_act_reg, iss_act_next;
    logic [IDX_W-1:0]   iss_idx_reg, iss_idx_next;

    // Circle memory.
    logic [ENT_W-1:0]   mem [MAX_CIRCLES];
    logic [ENT_W-1:0]   ent_reg;
    logic               ent_vld_reg, ent_vld_next;
    logic [IDX_W-1:0]   ent_idx_reg;

    // Compare unit, stage one: offsets and radius.
    logic [C-1:0]       ent_x, ent_y, ent_w, ent_h;
    logic [C:0]         cx, cy;
    logic signed [C+1:0] dx, dy;
    logic [ABS_W-1:0]   adx_next, ady_next;
    logic [ABS_W-1:0]   adx_reg, ady_reg;
    logic [C-2:0]       r_reg;
    logic               s1_vld_reg, s1_vld_next;
    logic [IDX_W-1:0]   s1_idx_reg;

    // Compare unit, stage two: squares.
    logic [SQ_W-1:0]    sqx_reg, sqy_reg, sqr_reg;
    logic               s2_vld_reg, s2_vld_next;
    logic [IDX_W-1:0]   s2_idx_reg;

    // Compare unit, stage three: sum and compare.
    logic [SUM_W-1:0]   dist2;
    logic               s2_hit;

    // Result registers.
    logic               done_reg, done_next;
    logic               hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               refused_reg, refused_next;

    assign busy       = (state_reg != cthit_pkg::ST_IDLE);
    assign accept     = start && !busy;
    assign table_full = (count_reg >= CNT_W'(MAX_CIRCLES));
    assign mem_we     = accept && (req_type == cthit_pkg::REQ_INSERT) && !table_full;

    // Memory: one write port for inserts, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= {circ_x, circ_y, circ_w, circ_h};
        end
        ent_reg <= mem[iss_idx_reg];
    end

    // Stage one: center offsets as magnitudes.
    assign {ent_x, ent_y, ent_w, ent_h} = ent_reg;
    assign cx = {1'b0, ent_x} + {2'b00, ent_w[C-1:1]};
    assign cy = {1'b0, ent_y} + {2'b00, ent_h[C-1:1]};
    assign dx = $signed({2'b00, px_reg}) - $signed({1'b0, cx});
    assign dy = $signed({2'b00, py_reg}) - $signed({1'b0, cy});

    always_comb
    begin
        adx_next = dx[C+1] ? ABS_W'(-dx) : ABS_W'(dx);
        ady_next = dy[C+1] ? ABS_W'(-dy) : ABS_W'(dy);
    end

    // Stage three: the point is inside when the squared distance is below r squared.
    assign dist2  = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    assign s2_hit = s2_vld_reg && (dist2 < SUM_W'(sqr_reg));

    // Datapath registers of the compare unit and the query point.
    always_ff @(posedge clk)
    begin
        if (accept && (req_type == cthit_pkg::REQ_QUERY))
        begin
            px_reg <= pt_x;
            py_reg <= pt_y;
        end
        ent_idx_reg <= iss_idx_reg;
        adx_reg     <= adx_next;
        ady_reg     <= ady_next;
        r_reg       <= ent_w[C-1:1];
        s1_idx_reg  <= ent_idx_reg;
        sqx_reg     <= SQ_W'(adx_reg) * SQ_W'(adx_reg);
        sqy_reg     <= SQ_W'(ady_reg) * SQ_W'(ady_reg);
        sqr_reg     <= SQ_W'(r_reg) * SQ_W'(r_reg);
        s2_idx_reg  <= s1_idx_reg;
        hit_idx_reg <= hit_idx_next;
        hit_found_reg <= hit_found_next;
        refused_reg <= refused_next;
    end

    // Sequencer: takes items, walks the table newest first, and reports.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        iss_act_next   = iss_act_reg;
        iss_idx_next   = iss_idx_reg;
        ent_vld_next   = 1'b0;
        s1_vld_next    = 1'b0;
        s2_vld_next    = 1'b0;
        done_next      = 1'b0;
        hit_found_next = 1'b0;
        hit_idx_next   = '0;
        refused_next   = 1'b0;

        case (state_reg)
            cthit_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == cthit_pkg::REQ_INSERT)
                    begin
                        done_next = 1'b1;
                        if (table_full)
                        begin
                            refused_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // An empty table misses at once.
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next   = cthit_pkg::ST_SCAN;
                        iss_act_next = 1'b1;
                        iss_idx_next = IDX_W'(count_reg - CNT_W'(1));
                    end
                end
            end

            cthit_pkg::ST_SCAN:
            begin
                if (s2_hit)
                begin
                    // First hit from the newest side ends the scan and drops the rest.
                    done_next      = 1'b1;
                    hit_found_next = 1'b1;
                    hit_idx_next   = s2_idx_reg;
                    iss_act_next   = 1'b0;
                    state_next     = cthit_pkg::ST_IDLE;
                end
                else if (!iss_act_reg && !ent_vld_reg && !s1_vld_reg && !s2_vld_reg)
                begin
                    // Every entry was tested without a hit.
                    done_next  = 1'b1;
                    state_next = cthit_pkg::ST_IDLE;
                end
                else
                begin
                    ent_vld_next = iss_act_reg;
                    s1_vld_next  = ent_vld_reg;
                    s2_vld_next  = s1_vld_reg;
                    if (iss_act_reg)
                    begin
                        iss_act_next = (iss_idx_reg != '0);
                        iss_idx_next = iss_idx_reg - IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next   = cthit_pkg::ST_IDLE;
                iss_act_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= cthit_pkg::ST_IDLE;
            count_reg   <= '0;
            iss_act_reg <= 1'b0;
            iss_idx_reg <= '0;
            ent_vld_reg <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            iss_act_reg <= iss_act_next;
            iss_idx_reg <= iss_idx_next;
            ent_vld_reg <= ent_vld_next;
            s1_vld_reg  <= s1_vld_next;
            s2_vld_reg  <= s2_vld_next;
            done_reg    <= done_next;
        end
    end

    // Result ports; the count already reflects the item being reported.
    assign done           = done_reg;
    assign hit_found      = hit_found_reg;
    assign hit_index      = cthit_pkg::hit_index_t'(hit_idx_reg);
    assign stored_count   = cthit_pkg::stored_count_t'(count_reg);
    assign insert_refused = refused_reg;

    // The scan pipeline is empty whenever the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cthit_pkg::ST_IDLE) |->
            (!iss_act_reg && !ent_vld_reg && !s1_vld_reg && !s2_vld_reg))
        else $error("scan pipeline active while idle");

    // The circle count never passes the table capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CIRCLES))
        else $error("circle count beyond capacity");

    // A refused insert never reports a hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && refused_reg) |-> !hit_found_reg)
        else $error("refused insert reported a hit");

    // A query on a non-empty table starts a scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == cthit_pkg::REQ_QUERY) && (count_reg != '0)) |=>
            (busy && !done_reg))
        else $error("query did not start a scan");

    // A hit always names a stored circle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_found_reg) |-> (CNT_W'(hit_idx_reg) < count_reg))
        else $error("hit index outside the stored circles");

endmodule

`default_nettype wire

[tb/tb_circle_table_hit_test.sv]
// Self-checking testbench for the circle table hit test: directed corners, then random traffic.
module tb_circle_table_hit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 8;
    localparam int CAPACITY       = 64;
    localparam int COORD_W        = 10;
    localparam int COORD_MAX      = (1 << COORD_W) - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    typedef logic [COORD_W-1:0] coord_t;

    // One request item as it goes onto the ports.
    typedef struct {
        logic   req_type;
        coord_t circ_x;
        coord_t circ_y;
        coord_t circ_w;
        coord_t circ_h;
        coord_t pt_x;
        coord_t pt_y;
    } request_t;

    // One result item as it comes off the ports.
    typedef struct {
        logic                     hit_found;
        cthit_pkg::hit_index_t    hit_index;
        cthit_pkg::stored_count_t stored_count;
        logic                     insert_refused;
    } answer_t;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   start = 1'b0;
    logic   req_type = cthit_pkg::REQ_INSERT;
    coord_t circ_x = '0;
    coord_t circ_y = '0;
    coord_t circ_w = '0;
    coord_t circ_h = '0;
    coord_t pt_x = '0;
    coord_t pt_y = '0;

    logic                     busy;
    logic                     done;
    logic                     hit_found;
    cthit_pkg::hit_index_t    hit_index;
    cthit_pkg::stored_count_t stored_count;
    logic                     insert_refused;

    // Shadow copy of the circle table.
    coord_t box_x [CAPACITY];
    coord_t box_y [CAPACITY];
    coord_t box_w [CAPACITY];
    coord_t box_h [CAPACITY];
    int     held_count = 0;

    answer_t pending_answers [$];
    int      error_count = 0;
    int      quiet_cycles = 0;
    bit      idle_on = 1'b1;

    circle_table_hit_test #(
        .MAX_CIRCLES(CAPACITY),
        .COORD_BITS (COORD_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .circ_x        (circ_x),
        .circ_y        (circ_y),
        .circ_w        (circ_w),
        .circ_h        (circ_h),
        .pt_x          (pt_x),
        .pt_y          (pt_y),
        .done          (done),
        .hit_found     (hit_found),
        .hit_index     (hit_index),
        .stored_count  (stored_count),
        .insert_refused(insert_refused)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Applies one accepted item to the shadow table and returns the result it must give.
    // The scan runs from the newest circle down and stops at the first one holding the point.
    function automatic answer_t answer_request(request_t rq);
        answer_t a;
        int      n;
        int      r;
        int      dx;
        int      dy;
        bit      found;
        a.hit_found      = 1'b0;
        a.hit_index      = '0;
        a.insert_refused = 1'b0;
        if (rq.req_type == cthit_pkg::REQ_INSERT)
        begin
            if (held_count >= CAPACITY)
            begin
                a.insert_refused = 1'b1;
            end
            else
            begin
                box_x[held_count] = rq.circ_x;
                box_y[held_count] = rq.circ_y;
                box_w[held_count] = rq.circ_w;
                box_h[held_count] = rq.circ_h;
                held_count++;
            end
        end
        else
        begin
            found = 1'b0;
            n = held_count - 1;
            while (!found && n >= 0)
            begin
                r  = int'(box_w[n]) >> 1;
                dx = int'(rq.pt_x) - (int'(box_x[n]) + r);
                dy = int'(rq.pt_y) - (int'(box_y[n]) + (int'(box_h[n]) >> 1));
                if (dx * dx + dy * dy < r * r)
                begin
                    found       = 1'b1;
                    a.hit_found = 1'b1;
                    a.hit_index = cthit_pkg::hit_index_t'(n);
                end
                n--;
            end
        end
        a.stored_count = cthit_pkg::stored_count_t'(held_count);
        return a;
    endfunction

    // Draws a random item. Queries aim near a stored circle most of the time so that
    // the scan ends on hits at every depth; the unused fields are random as well.
    function automatic request_t random_request(bit want_query);
        request_t rq;
        int       k;
        int       r;
        int       px;
        int       py;
        rq.req_type = want_query ? cthit_pkg::REQ_QUERY : cthit_pkg::REQ_INSERT;
        rq.circ_x   = coord_t'($urandom_range(0, COORD_MAX));
        rq.circ_y   = coord_t'($urandom_range(0, COORD_MAX));
        rq.circ_w   = ($urandom_range(0, 9) < 3) ? coord_t'($urandom_range(0, COORD_MAX))
                                                 : coord_t'($urandom_range(2, 200));
        rq.circ_h   = coord_t'($urandom_range(0, COORD_MAX));
        rq.pt_x     = coord_t'($urandom_range(0, COORD_MAX));
        rq.pt_y     = coord_t'($urandom_range(0, COORD_MAX));
        if (want_query && held_count > 0 && $urandom_range(0, 9) < 7)
        begin
            k  = $urandom_range(0, held_count - 1);
            r  = int'(box_w[k]) >> 1;
            px = int'(box_x[k]) + r + int'($urandom_range(0, 2 * r + 4)) - (r + 2);
            py = int'(box_y[k]) + (int'(box_h[k]) >> 1)
                 + int'($urandom_range(0, 2 * r + 4)) - (r + 2);
            rq.pt_x = coord_t'((px < 0) ? 0 : (px > COORD_MAX) ? COORD_MAX : px);
            rq.pt_y = coord_t'((py < 0) ? 0 : (py > COORD_MAX) ? COORD_MAX : py);
        end
        return rq;
    endfunction

    // Sends one item, after a random idle gap when gaps are on, and records its expected result.
    // Called at a rising edge; start stays high between items when there is no gap.
    task automatic send_item(request_t rq);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req_type <= rq.req_type;
        circ_x   <= rq.circ_x;
        circ_y   <= rq.circ_y;
        circ_w   <= rq.circ_w;
        circ_h   <= rq.circ_h;
        pt_x     <= rq.pt_x;
        pt_y     <= rq.pt_y;
        do @(posedge clk); while (busy);
        pending_answers.push_back(answer_request(rq));
    endtask

    task automatic send_fields(logic kind, int cx, int cy, int cw, int ch, int px, int py);
        request_t rq;
        rq.req_type = kind;
        rq.circ_x   = coord_t'(cx);
        rq.circ_y   = coord_t'(cy);
        rq.circ_w   = coord_t'(cw);
        rq.circ_h   = coord_t'(ch);
        rq.pt_x     = coord_t'(px);
        rq.pt_y     = coord_t'(py);
        send_item(rq);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
    endtask

    // Queries on an empty table must miss; insert fields on a query are ignored.
    task automatic test_empty_queries();
        send_fields(cthit_pkg::REQ_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, COORD_MAX, COORD_MAX);
    endtask

    // Widths of zero and one give a radius of zero, which holds no point, not even the center.
    task automatic test_degenerate_widths();
        send_fields(cthit_pkg::REQ_INSERT, 100, 100, 0, 0, COORD_MAX, COORD_MAX);
        send_fields(cthit_pkg::REQ_INSERT, 200, 200, 1, 1, 0, 0);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, 100, 100);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, 200, 200);
    endtask

    // Points on the circle edge miss, points just inside hit; a box at the far corner
    // puts its center outside the coordinate range.
    task automatic test_boundary_points();
        send_fields(cthit_pkg::REQ_INSERT, 0, 0, COORD_MAX, 0, 0, 0);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, 511, 0);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, 0, 0);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, 1, 0);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, 511, 511);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, 511, 510);
        send_fields(cthit_pkg::REQ_INSERT, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, COORD_MAX, COORD_MAX);
    endtask

    // Overlapping circles report the newest one; odd width and height round down.
    task automatic test_newest_wins();
        send_fields(cthit_pkg::REQ_INSERT, 300, 300, 200, 200, 0, 0);
        send_fields(cthit_pkg::REQ_INSERT, 350, 350, 200, 200, 0, 0);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, 420, 420);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, 320, 400);
        send_fields(cthit_pkg::REQ_INSERT, 500, 500, 101, 57, 0, 0);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, 599, 528);
        send_fields(cthit_pkg::REQ_QUERY, 0, 0, 0, 0, 600, 528);
    endtask

    // Random inserts mixed with aimed queries until the table is full.
    task automatic test_random_fill();
        int i;
        i = 0;
        while (held_count < CAPACITY)
        begin
            if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_item(random_request($urandom_range(0, 3) != 0));
            i++;
        end
    endtask

    // Full table: long scans that can run over every entry, with inserts that must be refused.
    task automatic test_full_table();
        int i;
        for (i = 0; i < 1050; i++)
        begin
            if (i % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_item(random_request($urandom_range(0, 9) != 0));
        end
    endtask

    // Check each result item against the oldest expectation.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result with no item outstanding");
                error_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (hit_found !== want.hit_found)
                begin
                    $error("hit_found expected %0d actual %0d", want.hit_found, hit_found);
                    error_count++;
                end
                if (hit_index !== want.hit_index)
                begin
                    $error("hit_index expected %0d actual %0d", want.hit_index, hit_index);
                    error_count++;
                end
                if (stored_count !== want.stored_count)
                begin
                    $error("stored_count expected %0d actual %0d",
                           want.stored_count, stored_count);
                    error_count++;
                end
                if (insert_refused !== want.insert_refused)
                begin
                    $error("insert_refused expected %0d actual %0d",
                           want.insert_refused, insert_refused);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queries();
        wait_drained();
        test_degenerate_widths();
        test_boundary_points();
        wait_drained();
        test_newest_wins();
        wait_drained();
        test_random_fill();
        wait_drained();
        test_full_table();
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
